// File: hw/rtl/pip_pkg.sv
// Shared widths, constants and pipeline control type for the Park / inverse Park block.
package pip_pkg;

    localparam int VEC_W  = 32;             // Q16.16 vector component
    localparam int TRIG_W = 16;             // Q1.15 sine / cosine
    localparam int PROD_W = VEC_W + TRIG_W; // full product
    localparam int SUM_W  = VEC_W + 1;      // sum of two saturated products
    localparam int SQ_W   = 2 * TRIG_W;     // sin^2 or cos^2
    localparam int DEF_W  = 32;             // norm deficit, range -2^30 .. 2^30

    localparam int PROD_SHIFT = 15;
    localparam int NORM_SHIFT = 30;
    localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'('h4000);
    localparam logic [SQ_W:0]   UNIT_SQ  = (SQ_W + 1)'(32768 * 32768);

    // correction path widths
    localparam int MUL_W  = SUM_W + DEF_W;      // sum times deficit
    localparam int CORR_W = MUL_W - NORM_SHIFT; // floor-shifted correction
    localparam int FIN_W  = CORR_W + 1;         // corrected sum before saturation

    // tdata layout of the input word
    localparam int IN_FIRST_LO  = 0;
    localparam int IN_SECOND_LO = IN_FIRST_LO + VEC_W;
    localparam int SIN_LO       = IN_SECOND_LO + VEC_W;
    localparam int COS_LO       = SIN_LO + TRIG_W;
    localparam int IN_DATA_W    = COS_LO + TRIG_W;
    localparam int OUT_DATA_W   = 2 * VEC_W;

    // load enables of the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

// File: hw/rtl/pip_norm.sv
// Norm deficit unit: 2^30 - (sin^2 + cos^2) in inverse mode, zero in forward mode.
module pip_norm (
    input  logic                              i_clk,
    input  pip_pkg::t_stage_en                i_ctl,
    input  logic signed [pip_pkg::TRIG_W-1:0] i_sin,
    input  logic signed [pip_pkg::TRIG_W-1:0] i_cos,
    input  logic                              i_inv,
    output logic signed [pip_pkg::DEF_W-1:0]  o_deficit
);

    logic signed [pip_pkg::SQ_W-1:0]  r_sq_s;
    logic signed [pip_pkg::SQ_W-1:0]  r_sq_c;
    logic                             r_inv;
    logic signed [pip_pkg::DEF_W-1:0] r_deficit;
    logic        [pip_pkg::SQ_W:0]    n_sq_sum;
    logic        [pip_pkg::SQ_W:0]    n_def;

    // stage 1: squares
    always_ff @(posedge i_clk) begin
        if (i_ctl.s1) begin
            r_sq_s <= i_sin * i_sin;
            r_sq_c <= i_cos * i_cos;
            r_inv  <= i_inv;
        end
    end

    // squares are non-negative, at most 2^30 each
    always_comb begin
        n_sq_sum = {1'b0, r_sq_s} + {1'b0, r_sq_c};
        n_def    = pip_pkg::UNIT_SQ - n_sq_sum;
    end

    // stage 2: deficit, aligned with the lane sums
    always_ff @(posedge i_clk) begin
        if (i_ctl.s2) begin
            r_deficit <= r_inv ? $signed(n_def[pip_pkg::DEF_W-1:0]) : '0;
        end
    end

    assign o_deficit = r_deficit;

endmodule

// File: hw/rtl/pip_lane.sv
// One rotation lane: a*u +/- b*v with rounded, saturated products and norm correction.
module pip_lane (
    input  logic                              i_clk,
    input  pip_pkg::t_stage_en                i_ctl,
    input  logic signed [pip_pkg::VEC_W-1:0]  i_a,
    input  logic signed [pip_pkg::VEC_W-1:0]  i_b,
    input  logic signed [pip_pkg::TRIG_W-1:0] i_u,
    input  logic signed [pip_pkg::TRIG_W-1:0] i_v,
    input  logic                              i_sub,
    input  logic signed [pip_pkg::DEF_W-1:0]  i_deficit,   // valid at stage 2 output
    output logic signed [pip_pkg::VEC_W-1:0]  o_result
);

    // round half away from zero, shift by 15, saturate to 32 bits
    function automatic logic [pip_pkg::VEC_W-1:0] f_round_sat(
        input logic [pip_pkg::PROD_W-1:0] p
    );
        logic [pip_pkg::PROD_W:0]                      t;
        logic [pip_pkg::PROD_W-pip_pkg::PROD_SHIFT:0]  q;
        t = {p[pip_pkg::PROD_W-1], p} + (p[pip_pkg::PROD_W-1]
            ? (pip_pkg::RND_HALF - (pip_pkg::PROD_W + 1)'(1)) : pip_pkg::RND_HALF);
        q = t[pip_pkg::PROD_W:pip_pkg::PROD_SHIFT];
        if ((&q[pip_pkg::PROD_W-pip_pkg::PROD_SHIFT:pip_pkg::VEC_W-1])
            || !(|q[pip_pkg::PROD_W-pip_pkg::PROD_SHIFT:pip_pkg::VEC_W-1])) begin
            return q[pip_pkg::VEC_W-1:0];
        end
        return q[pip_pkg::PROD_W-pip_pkg::PROD_SHIFT]
            ? {1'b1, {(pip_pkg::VEC_W-1){1'b0}}} : {1'b0, {(pip_pkg::VEC_W-1){1'b1}}};
    endfunction

    logic signed [pip_pkg::PROD_W-1:0] r_p1;
    logic signed [pip_pkg::PROD_W-1:0] r_p2;
    logic                              r_sub;
    logic        [pip_pkg::SUM_W-1:0]  r_sum;
    logic signed [pip_pkg::MUL_W-1:0]  r_mul;
    logic        [pip_pkg::SUM_W-1:0]  r_sum3;
    logic        [pip_pkg::VEC_W-1:0]  r_res;

    logic [pip_pkg::VEC_W-1:0] n_q1;
    logic [pip_pkg::VEC_W-1:0] n_q2;
    logic [pip_pkg::SUM_W-1:0] n_sum;
    logic [pip_pkg::FIN_W-1:0] n_fin;

    // stage 1: the two products
    always_ff @(posedge i_clk) begin
        if (i_ctl.s1) begin
            r_p1  <= i_a * i_u;
            r_p2  <= i_b * i_v;
            r_sub <= i_sub;
        end
    end

    always_comb begin
        n_q1  = f_round_sat(r_p1);
        n_q2  = f_round_sat(r_p2);
        n_sum = r_sub ? ({n_q1[pip_pkg::VEC_W-1], n_q1} - {n_q2[pip_pkg::VEC_W-1], n_q2})
                      : ({n_q1[pip_pkg::VEC_W-1], n_q1} + {n_q2[pip_pkg::VEC_W-1], n_q2});
    end

    // stage 2: exact sum of the saturated products
    always_ff @(posedge i_clk) begin
        if (i_ctl.s2) begin
            r_sum <= n_sum;
        end
    end

    // stage 3: sum times deficit (deficit is zero in forward mode)
    always_ff @(posedge i_clk) begin
        if (i_ctl.s3) begin
            r_mul  <= $signed(r_sum) * i_deficit;
            r_sum3 <= r_sum;
        end
    end

    // floor shift by 30 is the upper slice of the product
    always_comb begin
        n_fin = {{(pip_pkg::FIN_W-pip_pkg::SUM_W){r_sum3[pip_pkg::SUM_W-1]}}, r_sum3}
              + {r_mul[pip_pkg::MUL_W-1], r_mul[pip_pkg::MUL_W-1:pip_pkg::NORM_SHIFT]};
    end

    // stage 4: saturate into the output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.s4) begin
            if ((&n_fin[pip_pkg::FIN_W-1:pip_pkg::VEC_W-1])
                || !(|n_fin[pip_pkg::FIN_W-1:pip_pkg::VEC_W-1])) begin
                r_res <= n_fin[pip_pkg::VEC_W-1:0];
            end else begin
                r_res <= n_fin[pip_pkg::FIN_W-1] ? {1'b1, {(pip_pkg::VEC_W-1){1'b0}}}
                                                 : {1'b0, {(pip_pkg::VEC_W-1){1'b1}}};
            end
        end
    end

    assign o_result = $signed(r_res);

endmodule

// File: hw/rtl/park_inverse_park_transform.sv
// Top level: Park / inverse Park rotation, two lanes plus a norm unit in a 4-stage pipeline.
//
//  channel   dir  signals                          word content
//  s_axis    in   tvalid tready tdata[95:0] tuser  vector, sin, cos; tuser = mode
//  m_axis    out  tvalid tready tdata[63:0]        rotated vector
//
//  Throughput one word per cycle unless the output stalls; four register
//  stages: products, round/saturate/sum, correction multiply, final saturate.
//  Each output component has its own lane; the norm unit feeds both lanes.
//  Reset (synchronous, active low) clears the stage valid bits only.
//  Stalls: empty stages close up, so o_s_axis_tready drops only when all four
//  stages hold words and the output word is not being taken.
module park_inverse_park_transform (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [pip_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // in_first, in_second, sin_value, cos_value
    input  logic                             i_s_axis_tuser,  // req_type: 0 forward, 1 inverse
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [pip_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata   // out_first, out_second
);

    logic [3:0]         r_vld;   // [0] = stage 1 ... [3] = stage 4 (output)
    logic [3:0]         n_vld;
    logic [3:0]         w_adv;
    pip_pkg::t_stage_en w_ctl;

    logic signed [pip_pkg::VEC_W-1:0]  w_x;
    logic signed [pip_pkg::VEC_W-1:0]  w_y;
    logic signed [pip_pkg::TRIG_W-1:0] w_sin;
    logic signed [pip_pkg::TRIG_W-1:0] w_cos;
    logic signed [pip_pkg::DEF_W-1:0]  w_deficit;
    logic signed [pip_pkg::VEC_W-1:0]  w_out_first;
    logic signed [pip_pkg::VEC_W-1:0]  w_out_second;

    // unpack the input word
    assign w_x   = $signed(i_s_axis_tdata[pip_pkg::IN_FIRST_LO  +: pip_pkg::VEC_W]);
    assign w_y   = $signed(i_s_axis_tdata[pip_pkg::IN_SECOND_LO +: pip_pkg::VEC_W]);
    assign w_sin = $signed(i_s_axis_tdata[pip_pkg::SIN_LO       +: pip_pkg::TRIG_W]);
    assign w_cos = $signed(i_s_axis_tdata[pip_pkg::COS_LO       +: pip_pkg::TRIG_W]);

    // a stage moves when it is empty or the stage after it moves
    always_comb begin
        w_adv[3] = !r_vld[3] || i_m_axis_tready;
        w_adv[2] = !r_vld[2] || w_adv[3];
        w_adv[1] = !r_vld[1] || w_adv[2];
        w_adv[0] = !r_vld[0] || w_adv[1];
        w_ctl.s1 = w_adv[0];
        w_ctl.s2 = w_adv[1];
        w_ctl.s3 = w_adv[2];
        w_ctl.s4 = w_adv[3];
        n_vld[0] = w_adv[0] ? i_s_axis_tvalid : r_vld[0];
        n_vld[1] = w_adv[1] ? r_vld[0]        : r_vld[1];
        n_vld[2] = w_adv[2] ? r_vld[1]        : r_vld[2];
        n_vld[3] = w_adv[3] ? r_vld[2]        : r_vld[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // shared norm deficit (zero in forward mode)
    pip_norm u_norm (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_sin     (w_sin),
        .i_cos     (w_cos),
        .i_inv     (i_s_axis_tuser),
        .o_deficit (w_deficit)
    );

    // first component: fwd x*c + y*s, inv x*c - y*s
    pip_lane u_lane_first (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_a       (w_x),
        .i_b       (w_y),
        .i_u       (w_cos),
        .i_v       (w_sin),
        .i_sub     (i_s_axis_tuser),
        .i_deficit (w_deficit),
        .o_result  (w_out_first)
    );

    // second component: fwd y*c - x*s, inv y*c + x*s
    pip_lane u_lane_second (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_a       (w_y),
        .i_b       (w_x),
        .i_u       (w_cos),
        .i_v       (w_sin),
        .i_sub     (!i_s_axis_tuser),
        .i_deficit (w_deficit),
        .o_result  (w_out_second)
    );

    // merge: both lane output registers form the result word
    assign o_s_axis_tready = w_adv[0];
    assign o_m_axis_tvalid = r_vld[3];
    assign o_m_axis_tdata  = {w_out_second, w_out_first};

    // back pressure reaches the input only with every stage full
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_vld == 4'hF))
        else $error("input blocked while a pipeline stage is empty");

    // occupancy moves by at most one word per cycle
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_vld) <= $countones($past(r_vld)) + 1)
        && ($countones(r_vld) + 1 >= $countones($past(r_vld))))
        else $error("pipeline occupancy jumped");

    // a taken output with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && i_m_axis_tready && !r_vld[2]) |=> !r_vld[3])
        else $error("output word repeated after hand-off");

endmodule
